// ===== hw/rtl/skts_pkg.sv =====
// Shared types and codes for the sorted key table search block.
// No dependencies; imported by the controller, the datapath and the top level.
package skts_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_SEARCH = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    clear;
    logic    append;
    logic    gap_init;
    logic    gap_half;
    logic    pass_init;
    logic    rd_a;
    logic    rd_b;
    logic    hold_a;
    logic    wr1;
    logic    wr2;
    logic    idx_inc;
    logic    srch_init;
    logic    srch_rd_mid;
    logic    srch_step;
    logic    srch_rd_left;
    logic    res_set;
    logic    res_match;
    status_e res_status;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic gap_zero;
    logic idx_end;
    logic swapped;
    logic swap_need;
    logic srch_more;
    logic left_neg;
  } stat_t;

endpackage

// ===== hw/rtl/skts_datapath.sv =====
// Datapath: entry memory, counters, sort and search index registers, result registers.
// Depends on skts_pkg.
module skts_datapath #(
  parameter int DEPTH         = 256,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  skts_pkg::ctrl_t              ctrl_i,
  output skts_pkg::stat_t              stat_o,
  input  logic signed [31:0]           key_value_i,
  input  logic [PAYLOAD_WIDTH-1:0]     payload_tag_i,
  output logic [1:0]                   status_o,
  output logic [PAYLOAD_WIDTH-1:0]     found_payload_o,
  output logic [$clog2(DEPTH+1)-1:0]   entry_count_o
);
  import skts_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 32 + PAYLOAD_WIDTH;

  logic [EW-1:0]            mem_q [DEPTH];
  logic [EW-1:0]            rd_q;
  logic [EW-1:0]            ka_q;
  logic signed [31:0]       key_q;
  logic [PAYLOAD_WIDTH-1:0] tag_q;
  logic [CW-1:0]            cnt_q, gap_q, idx_q;
  logic                     swapped_q;
  logic signed [CW:0]       left_q, right_q, mid_q;
  logic [1:0]               status_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;

  logic [CW:0]        idxg;
  logic signed [CW:0] diff, mid;
  logic               full, we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [EW-1:0]      wdata;
  logic signed [31:0] rd_key, ka_key;

  assign rd_key = rd_q[EW-1:PAYLOAD_WIDTH];
  assign ka_key = ka_q[EW-1:PAYLOAD_WIDTH];
  assign idxg   = {1'b0, idx_q} + {1'b0, gap_q};
  assign diff   = right_q - left_q;
  assign mid    = left_q + (diff >>> 1);
  assign full   = (cnt_q >= CW'(DEPTH));

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[AW-1:0];
    wdata = {key_q, tag_q};
    if (ctrl_i.append && !full) begin
      we = 1'b1;
    end else if (ctrl_i.wr1) begin
      we    = 1'b1;
      waddr = idx_q[AW-1:0];
      wdata = rd_q;
    end else if (ctrl_i.wr2) begin
      we    = 1'b1;
      waddr = idxg[AW-1:0];
      wdata = ka_q;
    end
  end

  always_comb begin
    re    = ctrl_i.rd_a | ctrl_i.rd_b | ctrl_i.srch_rd_mid | ctrl_i.srch_rd_left;
    raddr = idx_q[AW-1:0];
    if (ctrl_i.rd_b) begin
      raddr = idxg[AW-1:0];
    end else if (ctrl_i.srch_rd_mid) begin
      raddr = mid[AW-1:0];
    end else if (ctrl_i.srch_rd_left) begin
      raddr = left_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
    if (ctrl_i.hold_a) begin
      ka_q <= rd_q;
    end
    if (ctrl_i.latch) begin
      key_q <= key_value_i;
      tag_q <= payload_tag_i;
    end
    if (ctrl_i.srch_rd_mid) begin
      mid_q <= mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      gap_q     <= '0;
      idx_q     <= '0;
      swapped_q <= 1'b0;
      left_q    <= '0;
      right_q   <= '0;
      status_q  <= ST_DONE;
      pay_q     <= '0;
    end else begin
      if (ctrl_i.clear) begin
        cnt_q <= '0;
      end else if (ctrl_i.append && !full) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (ctrl_i.gap_init) begin
        gap_q <= cnt_q >> 1;
      end else if (ctrl_i.gap_half) begin
        gap_q <= gap_q >> 1;
      end
      if (ctrl_i.pass_init) begin
        idx_q     <= '0;
        swapped_q <= 1'b0;
      end else begin
        if (ctrl_i.idx_inc) begin
          idx_q <= idx_q + CW'(1);
        end
        if (ctrl_i.wr1) begin
          swapped_q <= 1'b1;
        end
      end
      if (ctrl_i.srch_init) begin
        left_q  <= '1;
        right_q <= $signed({1'b0, cnt_q});
      end else if (ctrl_i.srch_step) begin
        if (rd_key > key_q) begin
          right_q <= mid_q;
        end else begin
          left_q <= mid_q;
        end
      end
      if (ctrl_i.res_set) begin
        if (ctrl_i.res_match) begin
          // hit only on an exact key match
          if (rd_key == key_q) begin
            status_q <= ST_DONE;
            pay_q    <= rd_q[PAYLOAD_WIDTH-1:0];
          end else begin
            status_q <= ST_MISSING;
            pay_q    <= '0;
          end
        end else begin
          status_q <= ctrl_i.res_status;
          pay_q    <= '0;
        end
      end
    end
  end

  assign stat_o.full      = full;
  assign stat_o.gap_zero  = (gap_q == '0);
  assign stat_o.idx_end   = (idxg >= {1'b0, cnt_q});
  assign stat_o.swapped   = swapped_q;
  assign stat_o.swap_need = (ka_key > rd_key);
  assign stat_o.srch_more = (diff > $signed((CW+1)'(1)));
  assign stat_o.left_neg  = left_q[CW];

  assign status_o        = status_q;
  assign found_payload_o = pay_q;
  assign entry_count_o   = cnt_q;

endmodule

// ===== hw/rtl/skts_controller.sv =====
// Controller state machine: sequences clear, append, sort and search on the datapath.
// Depends on skts_pkg.
module skts_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  skts_pkg::command_e command_i,
  input  skts_pkg::stat_t   stat_i,
  output skts_pkg::ctrl_t   ctrl_o
);
  import skts_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_CLR   = 16'h0002,
    S_APP   = 16'h0004,
    S_GINIT = 16'h0008,
    S_GAP   = 16'h0010,
    S_CHK   = 16'h0020,
    S_RDB   = 16'h0040,
    S_HOLD  = 16'h0080,
    S_CMP   = 16'h0100,
    S_WR2   = 16'h0200,
    S_QINIT = 16'h0400,
    S_QLOOP = 16'h0800,
    S_QCMP  = 16'h1000,
    S_QFIN  = 16'h2000,
    S_DONE  = 16'h4000,
    S_QMISS = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.res_status = ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.latch = 1'b1;
          unique case (command_i)
            CMD_CLEAR:  state_d = S_CLR;
            CMD_APPEND: state_d = S_APP;
            CMD_SORT:   state_d = S_GINIT;
            CMD_SEARCH: state_d = S_QINIT;
            default:    state_d = S_CLR;
          endcase
        end
      end
      S_CLR: begin
        ctrl_o.clear   = 1'b1;
        ctrl_o.res_set = 1'b1;
        state_d        = S_DONE;
      end
      S_APP: begin
        ctrl_o.append     = 1'b1;
        ctrl_o.res_set    = 1'b1;
        ctrl_o.res_status = stat_i.full ? ST_FULL : ST_DONE;
        state_d           = S_DONE;
      end
      S_GINIT: begin
        ctrl_o.gap_init = 1'b1;
        state_d         = S_GAP;
      end
      S_GAP: begin
        if (stat_i.gap_zero) begin
          ctrl_o.res_set = 1'b1;
          state_d        = S_DONE;
        end else begin
          ctrl_o.pass_init = 1'b1;
          state_d          = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat_i.idx_end) begin
          ctrl_o.rd_a = 1'b1;
          state_d     = S_RDB;
        end else if (stat_i.swapped) begin
          ctrl_o.pass_init = 1'b1;
        end else begin
          ctrl_o.gap_half = 1'b1;
          state_d         = S_GAP;
        end
      end
      S_RDB: begin
        ctrl_o.hold_a = 1'b1;
        ctrl_o.rd_b   = 1'b1;
        state_d       = S_HOLD;
      end
      S_HOLD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (stat_i.swap_need) begin
          ctrl_o.wr1 = 1'b1;
          state_d    = S_WR2;
        end else begin
          ctrl_o.idx_inc = 1'b1;
          state_d        = S_CHK;
        end
      end
      S_WR2: begin
        ctrl_o.wr2     = 1'b1;
        ctrl_o.idx_inc = 1'b1;
        state_d        = S_CHK;
      end
      S_QINIT: begin
        ctrl_o.srch_init = 1'b1;
        state_d          = S_QLOOP;
      end
      S_QLOOP: begin
        if (stat_i.srch_more) begin
          ctrl_o.srch_rd_mid = 1'b1;
          state_d            = S_QCMP;
        end else if (stat_i.left_neg) begin
          state_d = S_QMISS;
        end else begin
          ctrl_o.srch_rd_left = 1'b1;
          state_d             = S_QFIN;
        end
      end
      S_QCMP: begin
        ctrl_o.srch_step = 1'b1;
        state_d          = S_QLOOP;
      end
      S_QFIN: begin
        ctrl_o.res_set   = 1'b1;
        ctrl_o.res_match = 1'b1;
        state_d          = S_DONE;
      end
      S_QMISS: begin
        ctrl_o.res_set    = 1'b1;
        ctrl_o.res_status = ST_MISSING;
        state_d           = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ===== hw/rtl/sorted_key_table_search.sv =====
// Sorted key table search: a table of up to DEPTH key and payload pairs with
// clear, append, sort and exact-key binary search commands, one command at a
// time. A command transfer happens at a clock edge with start high and busy
// low; busy stays high until the result has been shown. Each command yields
// exactly one result, present on status_o, found_payload_o and entry_count_o
// for the single cycle in which done_o is high; the receiver cannot stall it,
// so capture it then. Keys are signed 16.16 fixed point and compare signed.
// The entry memory has registered read data. Clear and append act on the
// table and then raise done_o, and the next command is taken the cycle after
// done_o. A search makes one read and one compare per probe, then a read of
// the chosen entry. A sort of n held entries makes n - gap compares per pass,
// each with a read of both entries and, on a swap, two writes; passes repeat
// for each gap until one makes no swap, so its length depends on the data.
// Search on an unsorted table runs the same probe sequence over the stored
// order. Append to a full table leaves it unchanged and reports full. Memory
// contents need no clearing after reset: only entries below the count are
// ever read.
module sorted_key_table_search #(
  parameter int DEPTH         = 256,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command_i,
  input  logic signed [31:0]         key_value_i,
  input  logic [PAYLOAD_WIDTH-1:0]   payload_tag_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [PAYLOAD_WIDTH-1:0]   found_payload_o,
  output logic [$clog2(DEPTH+1)-1:0] entry_count_o
);
  import skts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencing: decode the command and step the datapath
  skts_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .done_o    (done_o),
    .command_i (command_e'(command_i)),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  // Storage, index arithmetic and result registers
  skts_datapath #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .key_value_i     (key_value_i),
    .payload_tag_i   (payload_tag_i),
    .status_o        (status_o),
    .found_payload_o (found_payload_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

// ===== tb/tb_sorted_key_table_search.sv =====
// Self-checking testbench for sorted_key_table_search.
// Depends on skts_pkg and the RTL only; holds its own table predictor and scoreboard.
`timescale 1ns / 1ps

module tb_sorted_key_table_search;
  import skts_pkg::*;

  localparam int DEPTH      = 256;
  localparam int PW         = 16;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int CYCLE_CAP  = 4000000;
  localparam int RAND_ITEMS = 160;

  typedef struct {
    status_e         st;
    logic [PW-1:0]   pay;
    logic [CW-1:0]   cnt;
  } table_result_t;

  // Predict each transfer's result from a private copy of the table and hold
  // the results in arrival order.
  class table_scoreboard;
    logic signed [31:0] keys [DEPTH];
    logic [PW-1:0]      tags [DEPTH];
    int                 held;
    table_result_t      pending [$];
    int                 mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function void sort_entries();
      int gap;
      bit swapped;
      logic signed [31:0] k;
      logic [PW-1:0] t;
      gap = held / 2;
      while (gap > 0) begin
        swapped = 1;
        while (swapped) begin
          swapped = 0;
          for (int i = 0; i + gap < held; i++) begin
            if (keys[i] > keys[i+gap]) begin
              k = keys[i]; keys[i] = keys[i+gap]; keys[i+gap] = k;
              t = tags[i]; tags[i] = tags[i+gap]; tags[i+gap] = t;
              swapped = 1;
            end
          end
        end
        gap = gap / 2;
      end
    endfunction

    function void note_transfer(command_e cmd, logic signed [31:0] key, logic [PW-1:0] tag);
      table_result_t r;
      int lo;
      int hi;
      int mid;
      r.st = ST_DONE;
      r.pay = '0;
      case (cmd)
        CMD_CLEAR: held = 0;
        CMD_APPEND: begin
          if (held >= DEPTH) r.st = ST_FULL;
          else begin
            keys[held] = key;
            tags[held] = tag;
            held++;
          end
        end
        CMD_SORT: sort_entries();
        default: begin
          lo = -1;
          hi = held;
          while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (!(keys[mid] > key)) lo = mid;
            else hi = mid;
          end
          if (lo < 0 || keys[lo] != key) r.st = ST_MISSING;
          else r.pay = tags[lo];
        end
      endcase
      r.cnt = CW'(held);
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [PW-1:0] pay, logic [CW-1:0] cnt);
      table_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d payload %h count %0d",
                                       st, pay, cnt);
        return;
      end
      e = pending.pop_front();
      if (st !== e.st || pay !== e.pay || cnt !== e.cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch at %0t: status %0d/%0d payload %h/%h count %0d/%0d",
                   $realtime, st, e.st, pay, e.pay, cnt, e.cnt);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           command_i;
  logic signed [31:0]   key_value_i;
  logic [PW-1:0]        payload_tag_i;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [PW-1:0]        found_payload_o;
  logic [CW-1:0]        entry_count_o;

  table_scoreboard sb;
  int idle_pct;
  logic signed [31:0] key_pool [12];

  sorted_key_table_search #(.DEPTH(DEPTH), .PAYLOAD_WIDTH(PW)) uut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .key_value_i, .payload_tag_i,
    .done_o, .status_o, .found_payload_o, .entry_count_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Capture every strobed result; the block cannot be stalled.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, found_payload_o, entry_count_o);
  end

  // Watchdog: end the run with a mismatch report once the cycle cap is passed.
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one command and hold it until busy is low at an edge (the transfer).
  // Leave start high so a back-to-back command needs no lowering.
  task automatic send_cmd(command_e cmd, logic signed [31:0] key, logic [PW-1:0] tag);
    command_i     <= cmd;
    key_value_i   <= key;
    payload_tag_i <= tag;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_transfer(cmd, key, tag);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 40 && sb.held > 0) return sb.keys[$urandom_range(sb.held - 1)];
    if (r < 50 && sb.held > 0) return sb.keys[$urandom_range(sb.held - 1)] + 1;
    if (r < 80) return key_pool[$urandom_range(11)];
    return $urandom;
  endfunction

  // Clear, fill the table past capacity, sort it whole, probe it, then clear it again.
  task automatic fill_table(output int n);
    n = 0;
    send_cmd(CMD_CLEAR, $urandom, PW'($urandom));
    n++;
    for (int i = 0; i < DEPTH + 2; i++) begin
      send_cmd(CMD_APPEND, $urandom, PW'($urandom));
      n++;
    end
    send_cmd(CMD_SORT, $urandom, PW'($urandom));
    n++;
    repeat (6) begin
      send_cmd(CMD_SEARCH, pick_key(), PW'($urandom));
      n++;
    end
    send_cmd(CMD_CLEAR, $urandom, PW'($urandom));
    n++;
  endtask

  // One random burst: a clear, a run of appends, a sort or a run of searches, often of held keys.
  task automatic random_burst(output int n);
    int r;
    n = 0;
    r = $urandom_range(99);
    if (r < 8 || sb.held > 40) begin
      send_cmd(CMD_CLEAR, $urandom, PW'($urandom));
      n = 1;
    end else if (r < 45) begin
      repeat ($urandom_range(1, 8)) begin
        send_cmd(CMD_APPEND, pick_key(), PW'($urandom));
        n++;
      end
    end else if (r < 60) begin
      send_cmd(CMD_SORT, $urandom, PW'($urandom));
      n = 1;
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_cmd(CMD_SEARCH, pick_key(), PW'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    int sent;
    int n;
    int goal;
    int idle_by_phase [4] = '{0, 73, 0, 24};
    sb = new();
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CMD_CLEAR;
    key_value_i = '0;
    payload_tag_i = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom_range(8) - 4;
    key_pool[0] = 32'sh7fffffff;
    key_pool[1] = 32'sh80000000;
    key_pool[2] = 32'sh00010000;
    key_pool[3] = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty search, extreme keys and tags, duplicates, unsorted search.
    send_cmd(CMD_SEARCH, 32'sd0, 16'h0);
    send_cmd(CMD_APPEND, 32'sh7fffffff, 16'hffff);
    send_cmd(CMD_APPEND, 32'sh80000000, 16'h0000);
    send_cmd(CMD_APPEND, 32'sd0, 16'h1111);
    send_cmd(CMD_APPEND, -32'sd1, 16'h2222);
    send_cmd(CMD_APPEND, 32'sd0, 16'h3333);
    send_cmd(CMD_SEARCH, 32'sd0, 16'h0);
    send_cmd(CMD_SORT, 32'sd0, 16'h0);
    send_cmd(CMD_SEARCH, 32'sh7fffffff, 16'h0);
    send_cmd(CMD_SEARCH, 32'sh80000000, 16'h0);
    send_cmd(CMD_SEARCH, 32'sd0, 16'h0);
    send_cmd(CMD_SEARCH, -32'sd1, 16'h0);
    send_cmd(CMD_SEARCH, 32'sd5, 16'h0);
    send_cmd(CMD_CLEAR, 32'sh5a5a5a5a, 16'ha5a5);
    send_cmd(CMD_APPEND, 32'sd5, 16'h0042);
    send_cmd(CMD_SEARCH, 32'sd3, 16'h0);
    send_cmd(CMD_SEARCH, 32'sd5, 16'h0);
    send_cmd(CMD_SORT, 32'sd0, 16'h0);
    send_cmd(CMD_CLEAR, 32'sd0, 16'h0);
    send_cmd(CMD_SORT, 32'sd0, 16'h0);

    // Random phases with varied sender gaps and a table fill in the third; drain fully between phases.
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_by_phase[p];
      if (p == 2) begin
        fill_table(n);
        sent += n;
      end
      goal = sent + RAND_ITEMS / 4;
      while (sent < goal) begin
        random_burst(n);
        sent += n;
      end
      drain_results();
    end

    repeat (30) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
